FILE: design/deferring_priority_scheduler_core_assert.svh
// Assertion macros used by the scheduler sequencer.
`ifndef DEFERRING_PRIORITY_SCHEDULER_CORE_ASSERT_SVH
`define DEFERRING_PRIORITY_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

FILE: design/dps_pkg.sv
// Types, codes and constants of the deferring priority scheduler.
`timescale 1ns / 1ps
package dps_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TAG_W           = 16;
  localparam int PRIO_W          = 16;
  localparam int OPCODE_W        = 2;
  localparam int STATUS_W        = 3;
  localparam int COUNT_W         = 6;

  localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SETPRI = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEFERRED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [OPCODE_W-1:0]      opcode;
    logic [TAG_W-1:0]         entry_tag;
    logic signed [PRIO_W-1:0] entry_priority;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [TAG_W-1:0]         out_tag;
    logic signed [PRIO_W-1:0] out_priority;
    logic                     wake;
    logic                     in_deferred;
    logic [COUNT_W-1:0]       entry_count;
  } out_item_t;

  // One stored table entry.
  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } entry_t;

endpackage

FILE: design/deferring_priority_scheduler_core.sv
// Top level of the deferring priority scheduler.
//
//  channel | signals                          | direction | payload
//  --------+----------------------------------+-----------+---------------------
//  in      | in_valid, in_ready, in_item      | to core   | opcode, tag, priority
//  out     | out_valid, out_ready, out_item   | from core | status, tag, prio, flags
//  cfg     | cfg_valid, cfg_ready, cfg_data   | to core   | defer_cutoff
//
// Push, unused opcode, empty pop or empty reprioritize: the sequencer goes straight to its
// result state, then the output register. Pop: a scan, newest to oldest, through the single
// table read port, a decide step, shift steps to close the gap if needed, then a result.
// Reprioritize: a scan over every entry, then a result.
// Reset (synchronous) empties the table and clears the deferred flag and cutoff;
// no clearing pass. The output register lets a new beat enter while a result waits.
`timescale 1ns / 1ps
module deferring_priority_scheduler_core #(
  parameter int QUEUE_DEPTH = dps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dps_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dps_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic signed [dps_pkg::PRIO_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  logic signed [dps_pkg::PRIO_W-1:0] defer_cutoff;
  logic                              res_valid;
  logic                              res_take;
  dps_pkg::out_item_t                res;
  logic                              wr_en;
  logic [IDX_W-1:0]                  wr_addr;
  dps_pkg::entry_t                   wr_data;
  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  dps_pkg::entry_t                   rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      defer_cutoff <= '0;
    end else if (cfg_valid && cfg_ready) begin
      defer_cutoff <= cfg_data;
    end
  end

  // output register: load when empty or being drained this cycle
  assign res_take = res_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item <= res;
    end
  end

  dps_seq #(
    .DEPTH(QUEUE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .cutoff   (defer_cutoff),
    .res_valid(res_valid),
    .res_take (res_take),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  dps_store #(
    .DEPTH(QUEUE_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

endmodule

FILE: design/dps_store.sv
// Entry table memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module dps_store #(
  parameter int DEPTH = dps_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  dps_pkg::entry_t    wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output dps_pkg::entry_t    rd_data
);

  dps_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/dps_seq.sv
// Sequencer: push, pop scan/select, reprioritize scan and gap-closing shift.
`timescale 1ns / 1ps
`include "deferring_priority_scheduler_core_assert.svh"
module dps_seq #(
  parameter int DEPTH = dps_pkg::QUEUE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dps_pkg::in_item_t                 in_item,
  input  logic signed [dps_pkg::PRIO_W-1:0] cutoff,
  output logic                              res_valid,
  input  logic                              res_take,
  output dps_pkg::out_item_t                res,
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output dps_pkg::entry_t                   wr_data,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  dps_pkg::entry_t                   rd_data
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SCAN_POP = 6'b000010,
    S_SCAN_SET = 6'b000100,
    S_DECIDE   = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t                              state;
  logic [CNT_W-1:0]                    cnt;
  logic                                flag;
  logic [IDX_W-1:0]                    pend_idx;
  logic [IDX_W-1:0]                    best_idx;
  logic [dps_pkg::TAG_W-1:0]           best_tag;
  logic signed [dps_pkg::PRIO_W-1:0]   best_prio;
  logic                                urgent;
  logic [dps_pkg::TAG_W-1:0]           req_tag;
  logic signed [dps_pkg::PRIO_W-1:0]   req_prio;
  logic [dps_pkg::STATUS_W-1:0]        r_status;
  logic [dps_pkg::TAG_W-1:0]           r_tag;
  logic signed [dps_pkg::PRIO_W-1:0]   r_prio;
  logic                                r_wake;

  logic                                accept;
  logic                                full;
  logic [IDX_W-1:0]                    last_idx;
  logic                                more;
  logic                                deferrable;
  logic                                tag_hit;
  logic signed [dps_pkg::PRIO_W-1:0]   rd_prio;
  logic                                serve;
  logic                                push_ok;
  logic                                shift_ok;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign full       = (cnt == CNT_W'(DEPTH));
  assign last_idx   = IDX_W'(cnt - CNT_W'(1));
  // another entry exists above the one whose data is on the read port
  assign more       = (CNT_W'(pend_idx) + CNT_W'(1)) < cnt;
  assign deferrable = $signed(in_item.entry_priority) >= cutoff;
  assign tag_hit    = (rd_data.tag == req_tag);
  assign rd_prio    = $signed(rd_data.prio);
  assign serve      = urgent || flag || (best_prio < cutoff);
  assign push_ok    = accept && in_item.opcode == dps_pkg::OP_PUSH && !full;
  assign shift_ok   = pend_idx != '0 && CNT_W'(pend_idx) < cnt;

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_idx - IDX_W'(1);
    wr_data = rd_data;
    rd_en   = 1'b0;
    rd_addr = pend_idx + IDX_W'(1);
    unique case (state)
      S_IDLE: begin
        if (accept && in_item.opcode == dps_pkg::OP_PUSH && !full) begin
          wr_en        = 1'b1;
          wr_addr      = IDX_W'(cnt);
          wr_data.tag  = in_item.entry_tag;
          wr_data.prio = in_item.entry_priority;
        end
        if (accept && cnt != '0) begin
          if (in_item.opcode == dps_pkg::OP_POP) begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
          end else if (in_item.opcode == dps_pkg::OP_SETPRI) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      S_SCAN_POP: begin
        if (pend_idx != '0) begin
          rd_en   = 1'b1;
          rd_addr = pend_idx - IDX_W'(1);
        end
      end
      S_SCAN_SET: begin
        if (tag_hit) begin
          wr_en        = 1'b1;
          wr_addr      = pend_idx;
          wr_data.prio = req_prio;
        end
        rd_en = more;
      end
      S_DECIDE: begin
        if (serve && best_idx != last_idx) begin
          rd_en   = 1'b1;
          rd_addr = best_idx + IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // close the gap: entry at pend_idx moves down one place
        wr_en = 1'b1;
        rd_en = more;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      flag  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req_tag  <= in_item.entry_tag;
            req_prio <= in_item.entry_priority;
            r_tag    <= '0;
            r_prio   <= '0;
            unique case (in_item.opcode)
              dps_pkg::OP_PUSH: begin
                state <= S_DONE;
                if (full) begin
                  r_status <= dps_pkg::ST_FULL;
                  r_wake   <= 1'b0;
                end else begin
                  r_status <= dps_pkg::ST_OK;
                  cnt      <= cnt + CNT_W'(1);
                  flag     <= flag && deferrable;
                  r_wake   <= !flag || !deferrable;
                end
              end
              dps_pkg::OP_POP: begin
                r_wake <= 1'b0;
                if (cnt == '0) begin
                  r_status <= dps_pkg::ST_EMPTY;
                  flag     <= 1'b0;
                  state    <= S_DONE;
                end else begin
                  pend_idx  <= last_idx;
                  best_idx  <= last_idx;
                  best_tag  <= '0;
                  best_prio <= dps_pkg::PRIO_MAX;
                  urgent    <= 1'b0;
                  state     <= S_SCAN_POP;
                end
              end
              dps_pkg::OP_SETPRI: begin
                r_wake   <= 1'b0;
                r_status <= dps_pkg::ST_NOTFOUND;
                if (cnt != '0) begin
                  pend_idx <= '0;
                  state    <= S_SCAN_SET;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                r_wake   <= 1'b0;
                r_status <= dps_pkg::ST_NOTFOUND;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_POP: begin
          // newest to oldest; first negative entry wins outright
          if (rd_prio < 0) begin
            best_idx  <= pend_idx;
            best_tag  <= rd_data.tag;
            best_prio <= rd_prio;
            urgent    <= 1'b1;
            state     <= S_DECIDE;
          end else begin
            if (rd_prio <= best_prio) begin
              best_idx  <= pend_idx;
              best_tag  <= rd_data.tag;
              best_prio <= rd_prio;
            end
            if (pend_idx == '0) begin
              state <= S_DECIDE;
            end else begin
              pend_idx <= pend_idx - IDX_W'(1);
            end
          end
        end
        S_SCAN_SET: begin
          if (tag_hit) begin
            r_status <= dps_pkg::ST_OK;
          end
          if (more) begin
            pend_idx <= pend_idx + IDX_W'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DECIDE: begin
          if (!serve) begin
            flag     <= 1'b1;
            r_status <= dps_pkg::ST_DEFERRED;
            state    <= S_DONE;
          end else begin
            r_status <= dps_pkg::ST_POPPED;
            r_tag    <= best_tag;
            r_prio   <= best_prio;
            if (best_idx == last_idx) begin
              cnt   <= cnt - CNT_W'(1);
              state <= S_DONE;
              if (cnt == CNT_W'(1)) begin
                flag <= 1'b0;
              end
            end else begin
              pend_idx <= best_idx + IDX_W'(1);
              state    <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (more) begin
            pend_idx <= pend_idx + IDX_W'(1);
          end else begin
            cnt   <= cnt - CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid        = (state == S_DONE);
  assign res.status       = r_status;
  assign res.out_tag      = r_tag;
  assign res.out_priority = r_prio;
  assign res.wake         = r_wake;
  assign res.in_deferred  = flag;
  assign res.entry_count  = dps_pkg::COUNT_W'(cnt);

  `DPS_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CNT_W'(DEPTH))
  `DPS_ASSERT_NOW(a_flag_needs_entry, clk, rst, flag, cnt != '0)
  `DPS_ASSERT_NOW(a_shift_range, clk, rst, state == S_SHIFT, shift_ok)
  `DPS_ASSERT_NEXT(a_push_grows, clk, rst, push_ok, cnt == $past(cnt) + CNT_W'(1))

endmodule

FILE: sim/tb_deferring_priority_scheduler_core.sv
// Self-checking testbench for the deferring priority scheduler core.
`timescale 1ns / 1ps
module tb_deferring_priority_scheduler_core;
  import dps_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 205;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 2 * DEPTH + 6;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    in_item_t  item;
    int        reps;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_ready;
  out_item_t                out_item;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic signed [PRIO_W-1:0] cfg_data;

  // Shadow of the scheduler table, flag and cutoff.
  entry_t                   sched_tab [DEPTH];
  int                       sched_fill;
  bit                       sched_defer;
  logic signed [PRIO_W-1:0] sched_cutoff;

  out_item_t   pending_results [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count;
  int unsigned cycle_count;
  bit          quiet;
  bit          hold_req;

  deferring_priority_scheduler_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_deferring_priority_scheduler_core NOT OK");
      $finish;
    end
  end

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t r;
    int        best;
    int        k;
    bit        urgent;
    bit        deferrable;
    r = '0;
    r.status = ST_NOTFOUND;
    case (it.opcode)
      OP_PUSH: begin
        if (sched_fill >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          deferrable = $signed(it.entry_priority) >= $signed(sched_cutoff);
          sched_tab[sched_fill].tag  = it.entry_tag;
          sched_tab[sched_fill].prio = it.entry_priority;
          sched_fill++;
          sched_defer = sched_defer && deferrable;
          r.wake = !sched_defer || !deferrable;
          r.status = ST_OK;
        end
      end
      OP_POP: begin
        if (sched_fill == 0) begin
          r.status = ST_EMPTY;
          sched_defer = 1'b0;
        end else begin
          best = sched_fill - 1;
          urgent = 1'b0;
          // newest urgent entry wins outright; otherwise lowest, oldest on a tie
          for (k = sched_fill - 1; k >= 0; k--) begin
            if ($signed(sched_tab[k].prio) < 0) begin
              best = k;
              urgent = 1'b1;
              break;
            end
            if ($signed(sched_tab[k].prio) <= $signed(sched_tab[best].prio)) best = k;
          end
          if (!urgent && !sched_defer &&
              $signed(sched_tab[best].prio) >= $signed(sched_cutoff)) begin
            sched_defer = 1'b1;
            r.status = ST_DEFERRED;
          end else begin
            r.out_tag      = sched_tab[best].tag;
            r.out_priority = sched_tab[best].prio;
            for (k = best; k < sched_fill - 1; k++) sched_tab[k] = sched_tab[k + 1];
            sched_fill--;
            if (sched_fill == 0) sched_defer = 1'b0;
            r.status = ST_POPPED;
          end
        end
      end
      OP_SETPRI: begin
        for (k = 0; k < sched_fill; k++) begin
          if (sched_tab[k].tag == it.entry_tag) begin
            sched_tab[k].prio = it.entry_priority;
            r.status = ST_OK;
          end
        end
      end
      default: ;
    endcase
    r.in_deferred = sched_defer;
    r.entry_count = COUNT_W'(sched_fill);
    return r;
  endfunction

  function automatic logic signed [PRIO_W-1:0] clamp_prio(int v);
    if (v > 32767) return PRIO_MAX;
    if (v < -32768) return 16'sh8000;
    return v[PRIO_W-1:0];
  endfunction

  // Priorities cluster around the cutoff, with urgent ones and extremes mixed in.
  function automatic logic signed [PRIO_W-1:0] pick_priority();
    int r;
    int c;
    r = $urandom_range(0, 99);
    c = int'(sched_cutoff);
    if (r < 8) return clamp_prio(-int'($urandom_range(1, 32768)));
    else if (r < 13) return PRIO_MAX;
    else if (r < 17) return 16'sh0000;
    else if (r < 27) return clamp_prio(c);
    else if (r < 33) return clamp_prio(c - 1);
    else if (r < 70) return clamp_prio(c + int'($urandom_range(0, 16)) - 8);
    else if (r < 85) return PRIO_W'($urandom_range(0, 32767));
    else return PRIO_W'($urandom_range(0, 65535));
  endfunction

  function automatic in_item_t pick_work(bit filling);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    it.entry_tag      = TAG_W'($urandom_range(0, 65535));
    it.entry_priority = pick_priority();
    if (r < (filling ? 70 : 15)) begin
      it.opcode = OP_PUSH;
      if (sched_fill != 0 && $urandom_range(0, 7) == 0)
        it.entry_tag = sched_tab[$urandom_range(0, sched_fill - 1)].tag;
    end else if (r < (filling ? 85 : 82)) begin
      it.opcode = OP_POP;
    end else if (r < 97) begin
      it.opcode = OP_SETPRI;
      if (sched_fill != 0 && $urandom_range(0, 3) != 0)
        it.entry_tag = sched_tab[$urandom_range(0, sched_fill - 1)].tag;
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  function automatic void add_row(logic [OPCODE_W-1:0] op, logic [TAG_W-1:0] tag,
                                  logic signed [PRIO_W-1:0] prio, int reps,
                                  bit typed, out_item_t want);
    stim_row_t row;
    row.item.opcode         = op;
    row.item.entry_tag      = tag;
    row.item.entry_priority = prio;
    row.reps  = reps;
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endfunction

  // Called right after a rising edge; returns at the edge that takes the beat.
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    predicted = schedule_step(it);
    pending_results.push_back(typed ? want : predicted);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cutoff(logic signed [PRIO_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sched_cutoff = value;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t exp;
    if (pending_results.size() == 0) begin
      $error("result with no expectation waiting: status %0d tag %0h", got.status,
             got.out_tag);
      mismatch_count++;
      return;
    end
    exp = pending_results.pop_front();
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      mismatch_count++;
    end
    if (got.out_tag !== exp.out_tag) begin
      $error("out_tag: expected %0h, got %0h", exp.out_tag, got.out_tag);
      mismatch_count++;
    end
    if (got.out_priority !== exp.out_priority) begin
      $error("out_priority: expected %0d, got %0d", exp.out_priority, got.out_priority);
      mismatch_count++;
    end
    if (got.wake !== exp.wake) begin
      $error("wake: expected %0d, got %0d", exp.wake, got.wake);
      mismatch_count++;
    end
    if (got.in_deferred !== exp.in_deferred) begin
      $error("in_deferred: expected %0d, got %0d", exp.in_deferred, got.in_deferred);
      mismatch_count++;
    end
    if (got.entry_count !== exp.entry_count) begin
      $error("entry_count: expected %0d, got %0d", exp.entry_count, got.entry_count);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_item);
  end

  // Result side: random stall bursts, one long hold on request, none when quiet.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int                       p;
    int                       i;
    int                       n;
    bit                       filling;
    logic signed [PRIO_W-1:0] cut;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    sched_fill     = 0;
    sched_defer    = 1'b0;
    sched_cutoff   = '0;

    // cutoff is 0 out of reset
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0});
    add_row(OP_SETPRI, 16'h1234, 16'sh0010, 1, 1'b1, '{ST_NOTFOUND, 0, 0, 0, 0, 0});
    add_row(OP_UNUSED, 16'hFFFF, 16'sh7FFF, 1, 1'b1, '{ST_NOTFOUND, 0, 0, 0, 0, 0});
    add_row(OP_PUSH,   16'hFFFF, 16'sh7FFF, 1, 1'b1, '{ST_OK, 0, 0, 1, 0, 1});
    add_row(OP_PUSH,   16'h0000, 16'sh8000, 1, 1'b1, '{ST_OK, 0, 0, 1, 0, 2});
    add_row(OP_PUSH,   16'h00A5, 16'sh0005, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b1,
            '{ST_POPPED, 16'h0000, 16'sh8000, 0, 0, 2});
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b1, '{ST_DEFERRED, 0, 0, 0, 1, 2});
    // deferrable push keeps the flag and does not wake; urgent one clears it
    add_row(OP_PUSH,   16'h5A5A, 16'sh0007, 1, 1'b0, '0);
    add_row(OP_PUSH,   16'h5A5A, 16'shFFFF, 1, 1'b0, '0);
    add_row(OP_SETPRI, 16'h5A5A, 16'sh0003, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_SETPRI, 16'h00A5, 16'sh8000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b1, '{ST_EMPTY, 0, 0, 0, 0, 0});
    // fill to the brim, then one more push is dropped
    add_row(OP_PUSH,   16'h8000, 16'sh0001, DEPTH, 1'b0, '0);
    add_row(OP_PUSH,   16'h7FFF, 16'shFFFF, 1, 1'b1, '{ST_FULL, 0, 0, 0, 0, DEPTH});
    add_row(OP_SETPRI, 16'h8000, 16'sh8000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);
    add_row(OP_POP,    16'h0000, 16'sh0000, 1, 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r])
      for (n = 0; n < directed_rows[r].reps; n++)
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);

    filling = 1'b1;
    for (p = 0; p < PHASES; p++) begin
      wait_drain();
      case (p)
        0: cut = 16'sh8000;
        1: cut = PRIO_MAX;
        2: cut = 16'sh0010;
        3: cut = 16'shFFFF;
        5: cut = 16'sh0001;
        7: cut = 16'sh0000;
        default: cut = PRIO_W'($urandom_range(0, 65535));
      endcase
      write_cutoff(cut);
      if (p == PHASES - 1) quiet = 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (sched_fill == 0) filling = 1'b1;
        else if (sched_fill >= DEPTH && $urandom_range(0, 5) == 0) filling = 1'b0;
        else if ($urandom_range(0, 60) == 0) filling = !filling;
        // long result-side hold while beats keep coming, so the input backs up
        if (p == 2 && i == 20) hold_req = 1'b1;
        send_item(pick_work(filling), 1'b0, '0);
      end
    end

    wait_drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_deferring_priority_scheduler_core OK");
    end else begin
      $display("tb_deferring_priority_scheduler_core NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/dps_pkg.sv
design/dps_store.sv
design/dps_seq.sv
design/deferring_priority_scheduler_core.sv
sim/tb_deferring_priority_scheduler_core.sv
